[design/lwd_pkg.sv]
// Shared types and constants for the LZSS window decompressor.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package lwd_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = 12;
    localparam int CNT_W        = 5;
    localparam logic [7:0] FLAG_FILL = 8'hFF;
    localparam logic [4:0] LEN_BIAS  = 5'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } out_beat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LIT_LO,
        ST_LIT_HI,
        ST_COPY
    } state_t;

    typedef enum logic [1:0] {
        PH_FLAG = 2'd0,
        PH_LOW  = 2'd1,
        PH_HIGH = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ISS_NONE,
        ISS_LIT_LO,
        ISS_LIT_HI,
        ISS_COPY
    } issue_t;

    typedef enum logic {
        SRC_LIT,
        SRC_MEM
    } src_t;

    typedef struct packed {
        logic   hold_low;
        logic   load_item;
        issue_t issue;
        logic   last;
    } cmd_t;

    typedef struct packed {
        logic can_issue;
        logic copy_final;
    } sts_t;

endpackage

`default_nettype wire

[design/lzss_window_decompressor.sv]
// Channel    | Handshake              | Payload
// in         | in_valid / in_ready    | in_data  (in_byte, in_last)
// out        | out_valid / out_ready  | out_data (out_byte, run_last)
//
// A byte that completes no item is taken with no output. A literal item emits 2 bytes, a match
// item 3 to 18, one per cycle while out_ready is high, set by the single history read port.
// Reset needs no clearing pass: history never written reads as zero, tracked by the write
// pointer and a wrap flag. Low out_ready holds the read stage and the output register.
// Top level of the LZSS decompressor; depends on lwd_pkg, lwd_ctrl and lwd_datapath.
`default_nettype none

module lzss_window_decompressor #(
    parameter int BLOCK_BYTES = 2048,
    parameter int BLOCK_USED  = 2040
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire lwd_pkg::in_beat_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output lwd_pkg::out_beat_t      out_data
);

    lwd_pkg::cmd_t cmd;
    lwd_pkg::sts_t sts;

    lwd_ctrl #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .BLOCK_USED  (BLOCK_USED)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .cmd      (cmd),
        .sts      (sts)
    );

    lwd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

[design/lwd_ctrl.sv]
// Stream parser and emission sequencer for the LZSS window decompressor.
// Depends on lwd_pkg; drives the datapath through cmd_t and reads sts_t.
`default_nettype none

module lwd_ctrl #(
    parameter int BLOCK_BYTES = 2048,
    parameter int BLOCK_USED  = 2040
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire lwd_pkg::in_beat_t in_data,
    output lwd_pkg::cmd_t         cmd,
    input  wire lwd_pkg::sts_t    sts
);

    localparam int POS_W = $clog2(BLOCK_BYTES);

    lwd_pkg::state_t  state_reg, state_next;
    lwd_pkg::phase_t  phase_reg, phase_next;
    logic [15:0]      flag_reg, flag_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             in_use;

    assign in_use = 32'(pos_reg) < 32'(BLOCK_USED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lwd_pkg::ST_IDLE;
            phase_reg <= lwd_pkg::PH_FLAG;
            flag_reg  <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            flag_reg  <= flag_next;
            pos_reg   <= pos_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        flag_next  = flag_reg;
        pos_next   = pos_reg;
        cmd        = '{hold_low: 1'b0, load_item: 1'b0,
                       issue: lwd_pkg::ISS_NONE, last: 1'b0};
        in_ready   = 1'b0;
        case (state_reg)
            lwd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_use)
                    begin
                        case (phase_reg)
                            lwd_pkg::PH_LOW:
                            begin
                                cmd.hold_low = 1'b1;
                                phase_next   = lwd_pkg::PH_HIGH;
                            end
                            lwd_pkg::PH_HIGH:
                            begin
                                cmd.load_item = 1'b1;
                                flag_next     = {1'b0, flag_reg[15:1]};
                                state_next    = flag_reg[0] ? lwd_pkg::ST_LIT_LO
                                                            : lwd_pkg::ST_COPY;
                                // group ends once the fill bits have shifted out
                                phase_next    = (flag_next[15:8] == 8'd0) ? lwd_pkg::PH_FLAG
                                                                          : lwd_pkg::PH_LOW;
                            end
                            default:
                            begin
                                flag_next  = {lwd_pkg::FLAG_FILL, in_data.in_byte};
                                phase_next = lwd_pkg::PH_LOW;
                            end
                        endcase
                    end
                    if (pos_reg == POS_W'(BLOCK_BYTES - 1))
                    begin
                        pos_next   = '0;
                        flag_next  = '0;
                        phase_next = lwd_pkg::PH_FLAG;
                    end
                    else
                    begin
                        pos_next = POS_W'(pos_reg + 1'b1);
                    end
                    if (in_data.in_last)
                    begin
                        pos_next   = '0;
                        flag_next  = '0;
                        phase_next = lwd_pkg::PH_FLAG;
                    end
                end
            end
            lwd_pkg::ST_LIT_LO:
            begin
                if (sts.can_issue)
                begin
                    cmd.issue  = lwd_pkg::ISS_LIT_LO;
                    state_next = lwd_pkg::ST_LIT_HI;
                end
            end
            lwd_pkg::ST_LIT_HI:
            begin
                if (sts.can_issue)
                begin
                    cmd.issue  = lwd_pkg::ISS_LIT_HI;
                    cmd.last   = 1'b1;
                    state_next = lwd_pkg::ST_IDLE;
                end
            end
            lwd_pkg::ST_COPY:
            begin
                if (sts.can_issue)
                begin
                    cmd.issue = lwd_pkg::ISS_COPY;
                    cmd.last  = sts.copy_final;
                    if (sts.copy_final)
                    begin
                        state_next = lwd_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = lwd_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_copy_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue == lwd_pkg::ISS_COPY && sts.copy_final) |=> state_reg == lwd_pkg::ST_IDLE)
        else $error("copy did not end after its final byte");
    a_load_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_item || cmd.hold_low) |-> (state_reg == lwd_pkg::ST_IDLE && in_valid))
        else $error("item byte taken outside an input beat");
    a_issue_gated: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue != lwd_pkg::ISS_NONE |-> sts.can_issue)
        else $error("byte issued while datapath was stalled");
`endif

endmodule

`default_nettype wire

[design/lwd_datapath.sv]
// History memory, copy addressing and output register of the decompressor.
// Depends on lwd_pkg; commanded by lwd_ctrl.
`default_nettype none

module lwd_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lwd_pkg::in_beat_t in_data,
    input  wire lwd_pkg::cmd_t     cmd,
    output lwd_pkg::sts_t          sts,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output lwd_pkg::out_beat_t     out_data
);

    localparam int AW = lwd_pkg::WIN_AW;

    logic [7:0]              hist_mem [lwd_pkg::WINDOW_DEPTH];
    logic [7:0]              mem_q;
    logic [AW-1:0]           wp_reg;
    logic                    wrapped_reg;
    logic [7:0]              lo_reg;
    logic [7:0]              hi_reg;
    logic [lwd_pkg::CNT_W-1:0] cnt_reg;

    logic                    p1_valid_reg;
    lwd_pkg::src_t           p1_sel_reg;
    logic [7:0]              p1_lit_reg;
    logic                    p1_last_reg;

    logic                    out_valid_reg;
    lwd_pkg::out_beat_t      out_data_reg;

    logic                    p1_move;
    logic [7:0]              p1_byte;
    logic                    issuing;
    logic [AW-1:0]           target;
    logic [AW-1:0]           src;
    logic                    fwd;
    logic                    written;

    assign p1_move = p1_valid_reg && (!out_valid_reg || out_ready);
    assign p1_byte = (p1_sel_reg == lwd_pkg::SRC_MEM) ? mem_q : p1_lit_reg;
    assign issuing = cmd.issue != lwd_pkg::ISS_NONE;

    // The issued byte lands one past any byte still waiting in the read stage.
    assign target  = AW'(wp_reg + {{(AW-1){1'b0}}, p1_valid_reg});
    assign src     = AW'(target - {hi_reg, lo_reg[7:4]} - 1'b1);
    assign fwd     = p1_valid_reg && (src == wp_reg);
    assign written = wrapped_reg || (src < wp_reg);

    assign sts.can_issue  = !p1_valid_reg || p1_move;
    assign sts.copy_final = cnt_reg == '0;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (p1_move)
        begin
            hist_mem[wp_reg] <= p1_byte;
        end
        if (cmd.issue == lwd_pkg::ISS_COPY)
        begin
            mem_q <= hist_mem[src];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hold_low)
        begin
            lo_reg <= in_data.in_byte;
        end
        if (cmd.load_item)
        begin
            hi_reg  <= in_data.in_byte;
            cnt_reg <= lwd_pkg::CNT_W'({1'b0, lo_reg[3:0]} + lwd_pkg::LEN_BIAS - 1'b1);
        end
        else if (cmd.issue == lwd_pkg::ISS_COPY)
        begin
            cnt_reg <= lwd_pkg::CNT_W'(cnt_reg - 1'b1);
        end
        if (issuing)
        begin
            p1_last_reg <= cmd.last;
            case (cmd.issue)
                lwd_pkg::ISS_LIT_LO:
                begin
                    p1_sel_reg <= lwd_pkg::SRC_LIT;
                    p1_lit_reg <= lo_reg;
                end
                lwd_pkg::ISS_LIT_HI:
                begin
                    p1_sel_reg <= lwd_pkg::SRC_LIT;
                    p1_lit_reg <= hi_reg;
                end
                default:
                begin
                    // take the byte being written this cycle, else the history read, or zero where never written
                    if (fwd)
                    begin
                        p1_sel_reg <= lwd_pkg::SRC_LIT;
                        p1_lit_reg <= p1_byte;
                    end
                    else if (written)
                    begin
                        p1_sel_reg <= lwd_pkg::SRC_MEM;
                        p1_lit_reg <= 8'd0;
                    end
                    else
                    begin
                        p1_sel_reg <= lwd_pkg::SRC_LIT;
                        p1_lit_reg <= 8'd0;
                    end
                end
            endcase
        end
        if (p1_move)
        begin
            out_data_reg <= '{out_byte: p1_byte, run_last: p1_last_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (p1_move)
            begin
                wp_reg <= AW'(wp_reg + 1'b1);
                if (wp_reg == '1)
                begin
                    wrapped_reg <= 1'b1;
                end
            end
            if (issuing)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (p1_move)
            begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_wp_advance: assert property (@(posedge clk) disable iff (!rst_n)
        p1_move |=> wp_reg == AW'($past(wp_reg) + 1'b1))
        else $error("write pointer did not follow an emitted byte");
    a_wp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !p1_move |=> $stable(wp_reg))
        else $error("write pointer moved without an emitted byte");
    a_wrap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        wrapped_reg |=> wrapped_reg)
        else $error("history wrap flag cleared");
`endif

endmodule

`default_nettype wire
